[hw/rtl/pscp_pkg.sv]
`default_nettype none

package pscp_pkg;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 40;

  // Action codes.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Register numbers.
  localparam logic [2:0] REG_DATA   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_CTRL   = 3'd3;
  localparam logic [2:0] REG_BAUD   = 3'd4;

  // Access sizes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Command kinds handed from the front to the back.
  localparam logic [3:0] K_NONE      = 4'd0;
  localparam logic [3:0] K_RD_DATA   = 4'd1;
  localparam logic [3:0] K_RD_STATUS = 4'd2;
  localparam logic [3:0] K_RD_MODE   = 4'd3;
  localparam logic [3:0] K_RD_CTRL   = 4'd4;
  localparam logic [3:0] K_RD_BAUD   = 4'd5;
  localparam logic [3:0] K_SEND      = 4'd6;
  localparam logic [3:0] K_WR_MODE   = 4'd7;
  localparam logic [3:0] K_WR_CTRL   = 4'd8;
  localparam logic [3:0] K_WR_BAUD   = 4'd9;
  localparam logic [3:0] K_TICK      = 4'd10;

  // Pad protocol phases.
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_SELECTED   = 2'd1;
  localparam logic [1:0] PH_DESELECTED = 2'd2;
  localparam logic [1:0] PH_TRANSFER   = 2'd3;

  // Reset values.
  localparam logic [7:0]  RX_RESET     = 8'hFF;
  localparam logic [9:0]  STATUS_RESET = 10'h005;
  localparam logic [8:0]  MODE_RESET   = 9'h00D;
  localparam logic [15:0] BAUD_RESET   = 16'h0088;
  localparam logic [15:0] BUTTONS_IDLE = 16'hFFFF;

  // Protocol bytes.
  localparam logic [7:0] PAD_ADDR  = 8'h01;
  localparam logic [7:0] CARD_ADDR = 8'h81;
  localparam logic [7:0] CMD_READ  = 8'h42;
  localparam logic [7:0] PAD_ID    = 8'h41;
  localparam logic [7:0] PAD_MARK  = 8'h5A;
  localparam logic [7:0] NO_ANSWER = 8'hFF;

  localparam logic [15:0] CTRL_KEEP_MASK = 16'hFFAF;
  localparam logic [9:0]  ACK_DELAY      = 10'd100;

  // Status and control bit positions.
  localparam int unsigned ST_RXNE   = 1;
  localparam int unsigned ST_PERR   = 3;
  localparam int unsigned ST_ACK    = 7;
  localparam int unsigned ST_IRQ    = 9;
  localparam int unsigned CT_SELECT = 1;
  localparam int unsigned CT_ACKIRQ = 4;
  localparam int unsigned CT_RESET  = 6;
  localparam int unsigned CT_IRQEN  = 12;
  localparam int unsigned CT_PORT2  = 13;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  size;
    logic [15:0] data;
    logic [15:0] buttons;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pad_serial_port_controller_top.sv]
// Channel   Direction  Word (tdata, lowest bit first)
// s_*       in         action[1:0] reg_select[4:2] access_size[6:5]
//                      write_data[38:7] buttons[54:39], zero pad to 56 bits
// m_*       out        read_data[31:0] irq_pulse[32] irq_request[33], zero pad to 40 bits
//
// One word is taken per cycle while the queue is not full. Its result passes through
// the queue and then the output register before it reaches m_tdata.
// The front decodes each word into a command, a two-entry queue holds it,
// and the back applies it to the registers and the pad machine.
// The back stalls only when its output register is full and m_tready is low.
// rst is synchronous and resets every register but the queue storage and the output word.
`default_nettype none

module pad_serial_port_controller_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // action, reg_select, access_size, write_data, buttons
  input  wire logic [pscp_pkg::IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // read_data, irq_pulse, irq_request
  output logic [pscp_pkg::OUT_W-1:0]      m_tdata
);
  import pscp_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  pscp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  pscp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  pscp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/pscp_front.sv]
`default_nettype none

module pscp_front (
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // action[1:0], reg_select[4:2], access_size[6:5], write_data[38:7], buttons[54:39]
  input  wire logic [pscp_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                       q_full,
  output logic                            push,
  output pscp_pkg::cmd_t                  cmd
);
  import pscp_pkg::*;

  logic [1:0]  action;
  logic [2:0]  reg_select;
  logic [1:0]  access_size;
  logic [31:0] write_data;
  logic [15:0] buttons;

  assign action      = s_tdata[1:0];
  assign reg_select  = s_tdata[4:2];
  assign access_size = s_tdata[6:5];
  assign write_data  = s_tdata[38:7];
  assign buttons     = s_tdata[54:39];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    cmd.kind    = K_NONE;
    cmd.size    = access_size;
    cmd.data    = write_data[15:0];
    cmd.buttons = buttons;
    case (action)
      ACT_READ: begin
        if (reg_select == REG_DATA) begin
          cmd.kind = K_RD_DATA;
        end else if (access_size == SIZE_HALF) begin
          case (reg_select)
            REG_STATUS: cmd.kind = K_RD_STATUS;
            REG_MODE:   cmd.kind = K_RD_MODE;
            REG_CTRL:   cmd.kind = K_RD_CTRL;
            REG_BAUD:   cmd.kind = K_RD_BAUD;
            default:    cmd.kind = K_NONE;
          endcase
        end else if (access_size != SIZE_BYTE && reg_select == REG_STATUS) begin
          // Word reads see only the status register.
          cmd.kind = K_RD_STATUS;
        end
      end
      ACT_WRITE: begin
        if (reg_select == REG_DATA) begin
          cmd.kind = K_SEND;
        end else if (access_size != SIZE_BYTE) begin
          case (reg_select)
            REG_MODE: cmd.kind = K_WR_MODE;
            REG_CTRL: cmd.kind = K_WR_CTRL;
            REG_BAUD: cmd.kind = K_WR_BAUD;
            default:  cmd.kind = K_NONE;
          endcase
        end
      end
      ACT_TICK: cmd.kind = K_TICK;
      default:  cmd.kind = K_NONE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/pscp_queue.sv]
`default_nettype none

module pscp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  pscp_pkg::cmd_t      push_cmd,
  input  wire logic           pop,
  output pscp_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);
  import pscp_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_ptr_sync: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/pscp_back.sv]
`default_nettype none

module pscp_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  pscp_pkg::cmd_t                  cmd,
  input  wire logic                       q_empty,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // read_data[31:0], irq_pulse[32], irq_request[33]
  output logic [pscp_pkg::OUT_W-1:0]      m_tdata
);
  import pscp_pkg::*;

  logic [7:0]  rx_byte,         rx_byte_next;
  logic [9:0]  status_bits,     status_bits_next;
  logic [8:0]  mode_reg,        mode_reg_next;
  logic [15:0] control_reg,     control_reg_next;
  logic [15:0] baud_reg,        baud_reg_next;
  logic [1:0]  proto_phase,     proto_phase_next;
  logic [1:0]  reply_index,     reply_index_next;
  logic [15:0] latched_buttons, latched_buttons_next;
  logic        ack_pending,     ack_pending_next;
  logic [9:0]  ack_countdown,   ack_countdown_next;

  logic        out_valid;
  logic [33:0] out_word;
  logic [31:0] rd;
  logic        pulse;

  assign pop      = !q_empty && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - 34){1'b0}}, out_word};

  always_comb begin
    logic        ans;
    logic        ans_ack;
    logic [7:0]  ans_byte;
    logic        restart;
    logic        full_rst;
    logic [15:0] ctrl_val;

    ans      = 1'b0;
    ans_ack  = 1'b0;
    ans_byte = NO_ANSWER;
    restart  = 1'b0;
    full_rst = 1'b0;
    ctrl_val = cmd.data & CTRL_KEEP_MASK;
    rd       = 32'd0;
    pulse    = 1'b0;

    rx_byte_next         = rx_byte;
    status_bits_next     = status_bits;
    mode_reg_next        = mode_reg;
    control_reg_next     = control_reg;
    baud_reg_next        = baud_reg;
    proto_phase_next     = proto_phase;
    reply_index_next     = reply_index;
    latched_buttons_next = latched_buttons;
    ack_pending_next     = ack_pending;
    ack_countdown_next   = ack_countdown;

    case (cmd.kind)
      K_RD_DATA: begin
        case (cmd.size)
          SIZE_BYTE: rd = {24'd0, rx_byte};
          SIZE_HALF: rd = {16'd0, rx_byte, rx_byte};
          default:   rd = {4{rx_byte}};
        endcase
        status_bits_next[ST_RXNE] = 1'b0;
      end
      K_RD_STATUS: rd = {22'd0, status_bits};
      K_RD_MODE:   rd = {23'd0, mode_reg};
      K_RD_CTRL:   rd = {16'd0, control_reg};
      K_RD_BAUD:   rd = {16'd0, baud_reg};
      K_SEND: begin
        ans = 1'b1;
        if (control_reg[CT_PORT2]) begin
          restart = 1'b1;
        end else begin
          case (proto_phase)
            PH_IDLE: begin
              if (cmd.data[7:0] == PAD_ADDR) begin
                ans_ack          = 1'b1;
                proto_phase_next = PH_SELECTED;
              end else if (cmd.data[7:0] == CARD_ADDR) begin
                proto_phase_next = PH_DESELECTED;
              end
            end
            PH_SELECTED: begin
              if (cmd.data[7:0] == CMD_READ) begin
                latched_buttons_next = cmd.buttons;
                proto_phase_next     = PH_TRANSFER;
                reply_index_next     = 2'd0;
                ans_byte             = PAD_ID;
                ans_ack              = 1'b1;
              end else begin
                proto_phase_next = PH_IDLE;
              end
            end
            PH_DESELECTED: ans_byte = NO_ANSWER;
            default: begin
              case (reply_index)
                2'd0: begin
                  reply_index_next = 2'd1;
                  ans_byte         = PAD_MARK;
                  ans_ack          = 1'b1;
                end
                2'd1: begin
                  reply_index_next = 2'd2;
                  ans_byte         = latched_buttons[7:0];
                  ans_ack          = 1'b1;
                end
                2'd2: begin
                  proto_phase_next = PH_IDLE;
                  reply_index_next = 2'd0;
                  ans_byte         = latched_buttons[15:8];
                end
                default: begin
                  proto_phase_next = PH_IDLE;
                  reply_index_next = 2'd0;
                end
              endcase
            end
          endcase
        end
      end
      K_WR_MODE: mode_reg_next = cmd.data[8:0];
      K_WR_CTRL: begin
        if (cmd.data[CT_ACKIRQ]) begin
          status_bits_next[ST_PERR] = 1'b0;
          status_bits_next[ST_IRQ]  = 1'b0;
        end
        if (cmd.data[CT_RESET]) begin
          full_rst = 1'b1;
        end else begin
          control_reg_next = ctrl_val;
          // Dropping the select line restarts the pad protocol.
          if (control_reg[CT_SELECT] && !ctrl_val[CT_SELECT]) begin
            restart = 1'b1;
          end
        end
      end
      K_WR_BAUD: baud_reg_next = cmd.data;
      K_TICK: begin
        if (ack_pending) begin
          if (ack_countdown <= 10'd1) begin
            ack_pending_next         = 1'b0;
            ack_countdown_next       = 10'd0;
            status_bits_next[ST_ACK] = 1'b0;
            if (control_reg[CT_IRQEN]) begin
              status_bits_next[ST_IRQ] = 1'b1;
              pulse                    = 1'b1;
            end
          end else begin
            ack_countdown_next = ack_countdown - 10'd1;
          end
        end
      end
      default: rd = 32'd0;
    endcase

    if (ans) begin
      rx_byte_next              = ans_byte;
      status_bits_next[ST_RXNE] = 1'b1;
      status_bits_next[ST_ACK]  = ans_ack;
      if (ans_ack) begin
        ack_pending_next   = 1'b1;
        ack_countdown_next = ACK_DELAY;
      end
    end

    if (restart) begin
      proto_phase_next     = PH_IDLE;
      reply_index_next     = 2'd0;
      latched_buttons_next = BUTTONS_IDLE;
      ack_pending_next     = 1'b0;
      ack_countdown_next   = 10'd0;
    end

    if (full_rst) begin
      rx_byte_next         = RX_RESET;
      status_bits_next     = STATUS_RESET;
      mode_reg_next        = MODE_RESET;
      control_reg_next     = 16'd0;
      baud_reg_next        = BAUD_RESET;
      proto_phase_next     = PH_IDLE;
      reply_index_next     = 2'd0;
      latched_buttons_next = BUTTONS_IDLE;
      ack_pending_next     = 1'b0;
      ack_countdown_next   = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_byte         <= RX_RESET;
      status_bits     <= STATUS_RESET;
      mode_reg        <= MODE_RESET;
      control_reg     <= 16'd0;
      baud_reg        <= BAUD_RESET;
      proto_phase     <= PH_IDLE;
      reply_index     <= 2'd0;
      latched_buttons <= BUTTONS_IDLE;
      ack_pending     <= 1'b0;
      ack_countdown   <= 10'd0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        rx_byte         <= rx_byte_next;
        status_bits     <= status_bits_next;
        mode_reg        <= mode_reg_next;
        control_reg     <= control_reg_next;
        baud_reg        <= baud_reg_next;
        proto_phase     <= proto_phase_next;
        reply_index     <= reply_index_next;
        latched_buttons <= latched_buttons_next;
        ack_pending     <= ack_pending_next;
        ack_countdown   <= ack_countdown_next;
        out_valid       <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= {status_bits_next[ST_IRQ], pulse, rd};
    end
  end

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !ack_pending |-> ack_countdown == 10'd0)
    else $error("countdown running with no acknowledge pending");
  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    ack_pending |-> ack_countdown != 10'd0)
    else $error("acknowledge pending with an empty countdown");
  a_index_phase: assert property (@(posedge clk) disable iff (rst)
    proto_phase != PH_TRANSFER |-> reply_index == 2'd0)
    else $error("reply index left set outside a transfer");
  a_pulse_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word[32] |-> out_word[33])
    else $error("interrupt pulse without the request bit");

endmodule

`default_nettype wire

[tb/pad_serial_port_controller_top_test.sv]
module pad_serial_port_controller_top_test;
  import pscp_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_WIDE = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam logic [15:0] CTRL_SELECT = 16'h1 << CT_SELECT;
  localparam logic [15:0] CTRL_ACKIRQ = 16'h1 << CT_ACKIRQ;
  localparam logic [15:0] CTRL_RESET  = 16'h1 << CT_RESET;
  localparam logic [15:0] CTRL_IRQEN  = 16'h1 << CT_IRQEN;
  localparam logic [15:0] CTRL_PORT2  = 16'h1 << CT_PORT2;

  typedef struct {
    logic [1:0]  action;
    logic [2:0]  sel;
    logic [1:0]  size;
    logic [31:0] wdata;
    logic [15:0] buttons;
  } bus_op_t;

  typedef struct {
    logic [31:0] rdata;
    logic        pulse;
    logic        irq;
  } port_reply_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  pad_serial_port_controller_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Shadow copy of the port registers and the pad machine.
  logic [7:0]  rx_q;
  logic [9:0]  stat_q;
  logic [8:0]  mode_q;
  logic [15:0] ctrl_q;
  logic [15:0] baud_q;
  logic [1:0]  phase_q;
  logic [1:0]  reply_q;
  logic [15:0] held_buttons;
  logic        ack_armed;
  logic [9:0]  ack_left;

  port_reply_t replies_due[$];
  int unsigned fault_count = 0;
  int unsigned items_sent = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  function automatic void pad_restart();
    phase_q = PH_IDLE;
    reply_q = 2'd0;
    held_buttons = BUTTONS_IDLE;
    ack_armed = 1'b0;
    ack_left = '0;
  endfunction

  function automatic void port_reset();
    rx_q = RX_RESET;
    stat_q = STATUS_RESET;
    mode_q = MODE_RESET;
    ctrl_q = '0;
    baud_q = BAUD_RESET;
    pad_restart();
  endfunction

  function automatic void pad_answer(logic [7:0] b, logic ack);
    rx_q = b;
    stat_q[ST_RXNE] = 1'b1;
    if (ack) begin
      stat_q[ST_ACK] = 1'b1;
      ack_armed = 1'b1;
      ack_left = ACK_DELAY;
    end else begin
      stat_q[ST_ACK] = 1'b0;
    end
  endfunction

  function automatic void pad_send(logic [7:0] tx, logic [15:0] btn);
    if (ctrl_q[CT_PORT2]) begin
      pad_answer(NO_ANSWER, 1'b0);
      pad_restart();
      return;
    end
    case (phase_q)
      PH_IDLE: begin
        if (tx == PAD_ADDR) begin
          pad_answer(NO_ANSWER, 1'b1);
          phase_q = PH_SELECTED;
        end else if (tx == CARD_ADDR) begin
          pad_answer(NO_ANSWER, 1'b0);
          phase_q = PH_DESELECTED;
        end else begin
          pad_answer(NO_ANSWER, 1'b0);
        end
      end
      PH_SELECTED: begin
        if (tx == CMD_READ) begin
          held_buttons = btn;
          phase_q = PH_TRANSFER;
          reply_q = 2'd0;
          pad_answer(PAD_ID, 1'b1);
        end else begin
          pad_answer(NO_ANSWER, 1'b0);
          phase_q = PH_IDLE;
        end
      end
      PH_DESELECTED: pad_answer(NO_ANSWER, 1'b0);
      default: begin
        case (reply_q)
          2'd0: begin
            reply_q = 2'd1;
            pad_answer(PAD_MARK, 1'b1);
          end
          2'd1: begin
            reply_q = 2'd2;
            pad_answer(held_buttons[7:0], 1'b1);
          end
          2'd2: begin
            phase_q = PH_IDLE;
            reply_q = 2'd0;
            pad_answer(held_buttons[15:8], 1'b0);
          end
          default: begin
            phase_q = PH_IDLE;
            reply_q = 2'd0;
            pad_answer(NO_ANSWER, 1'b0);
          end
        endcase
      end
    endcase
  endfunction

  function automatic void control_write(logic [15:0] v);
    logic [15:0] prev;
    prev = ctrl_q;
    if (v[CT_ACKIRQ]) begin
      stat_q[ST_PERR] = 1'b0;
      stat_q[ST_IRQ] = 1'b0;
    end
    if (v[CT_RESET]) begin
      port_reset();
      return;
    end
    ctrl_q = v & CTRL_KEEP_MASK;
    if (prev[CT_SELECT] && !ctrl_q[CT_SELECT]) pad_restart();
  endfunction

  function automatic port_reply_t port_response(bus_op_t op);
    port_reply_t r;
    r.rdata = '0;
    r.pulse = 1'b0;
    case (op.action)
      ACT_READ: begin
        if (op.sel == REG_DATA) begin
          case (op.size)
            SIZE_BYTE: r.rdata = {24'h0, rx_q};
            SIZE_HALF: r.rdata = {16'h0, rx_q, rx_q};
            default:   r.rdata = {4{rx_q}};
          endcase
          stat_q[ST_RXNE] = 1'b0;
        end else if (op.size == SIZE_HALF) begin
          case (op.sel)
            REG_STATUS: r.rdata = {22'h0, stat_q};
            REG_MODE:   r.rdata = {23'h0, mode_q};
            REG_CTRL:   r.rdata = {16'h0, ctrl_q};
            REG_BAUD:   r.rdata = {16'h0, baud_q};
            default: ;
          endcase
        end else if (op.size != SIZE_BYTE && op.sel == REG_STATUS) begin
          r.rdata = {22'h0, stat_q};
        end
      end
      ACT_WRITE: begin
        if (op.sel == REG_DATA) begin
          pad_send(op.wdata[7:0], op.buttons);
        end else if (op.size != SIZE_BYTE) begin
          case (op.sel)
            REG_MODE: mode_q = op.wdata[8:0];
            REG_CTRL: control_write(op.wdata[15:0]);
            REG_BAUD: baud_q = op.wdata[15:0];
            default: ;
          endcase
        end
      end
      ACT_TICK: begin
        if (ack_armed) begin
          if (ack_left <= 10'd1) begin
            ack_armed = 1'b0;
            ack_left = '0;
            stat_q[ST_ACK] = 1'b0;
            if (ctrl_q[CT_IRQEN]) begin
              stat_q[ST_IRQ] = 1'b1;
              r.pulse = 1'b1;
            end
          end else begin
            ack_left = ack_left - 10'd1;
          end
        end
      end
      default: ;
    endcase
    r.irq = stat_q[ST_IRQ];
    return r;
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    port_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected word on m_tdata: %h", m_tdata);
      end else begin
        want = replies_due.pop_front();
        if (m_tdata[31:0] !== want.rdata || m_tdata[32] !== want.pulse ||
            m_tdata[33] !== want.irq) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: want rdata %h pulse %b irq %b, got rdata %h pulse %b irq %b",
                     want.rdata, want.pulse, want.irq,
                     m_tdata[31:0], m_tdata[32], m_tdata[33]);
        end
      end
    end
  end

  function automatic bus_op_t make_op(logic [1:0] action, logic [2:0] sel, logic [1:0] size,
                                      logic [31:0] wdata, logic [15:0] btn);
    bus_op_t op;
    op.action = action;
    op.sel = sel;
    op.size = size;
    op.wdata = wdata;
    op.buttons = btn;
    return op;
  endfunction

  task automatic send_op(input bus_op_t op);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, op.buttons, op.wdata, op.size, op.sel, op.action};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    replies_due.push_back(port_response(op));
    items_sent++;
  endtask

  task automatic bus_read(input logic [2:0] sel, input logic [1:0] size);
    send_op(make_op(ACT_READ, sel, size, $urandom(), 16'($urandom())));
  endtask

  task automatic bus_write(input logic [2:0] sel, input logic [1:0] size,
                           input logic [31:0] wdata);
    send_op(make_op(ACT_WRITE, sel, size, wdata, 16'($urandom())));
  endtask

  // Any access size sends the byte, so the size is left to chance.
  task automatic pad_byte(input logic [7:0] tx, input logic [15:0] btn);
    logic [31:0] w;
    w = $urandom();
    w[7:0] = tx;
    send_op(make_op(ACT_WRITE, REG_DATA, 2'($urandom_range(SIZE_WIDE, SIZE_BYTE)), w, btn));
  endtask

  task automatic control_set(input logic [15:0] v);
    logic [31:0] w;
    w = $urandom();
    w[15:0] = v;
    bus_write(REG_CTRL, 2'($urandom_range(SIZE_WIDE, SIZE_HALF)), w);
  endtask

  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) send_op(make_op(ACT_TICK, 3'($urandom()), 2'($urandom()),
                                                $urandom(), 16'($urandom())));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic test_register_file();
    bus_read(REG_STATUS, SIZE_WORD);
    bus_read(REG_STATUS, SIZE_HALF);
    bus_read(REG_STATUS, SIZE_BYTE);
    bus_read(REG_MODE, SIZE_HALF);
    bus_read(REG_CTRL, SIZE_HALF);
    bus_read(REG_BAUD, SIZE_HALF);
    bus_read(REG_MODE, SIZE_WORD);
    bus_read(REG_DATA, SIZE_BYTE);
    bus_read(REG_DATA, SIZE_HALF);
    bus_read(REG_DATA, SIZE_WIDE);
    bus_write(REG_MODE, SIZE_BYTE, 32'hFFFF_FFFF);
    bus_write(REG_MODE, SIZE_HALF, 32'hFFFF_FFFF);
    bus_write(REG_BAUD, SIZE_WIDE, 32'hFFFF_FFFF);
    bus_write(REG_STATUS, SIZE_WORD, 32'hFFFF_FFFF);
    bus_write(REG_SPARE_HI, SIZE_WORD, 32'hFFFF_FFFF);
    bus_read(REG_SPARE_LO, SIZE_HALF);
    bus_read(REG_MODE, SIZE_HALF);
    bus_read(REG_BAUD, SIZE_HALF);
    send_op(make_op(ACT_SPARE, REG_DATA, SIZE_WORD, 32'hFFFF_FFFF, 16'hFFFF));
    bus_write(REG_CTRL, SIZE_WORD, {16'hFFFF, ~CTRL_RESET});
    bus_read(REG_CTRL, SIZE_HALF);
    // Reset through the control register brings back every reset value.
    bus_write(REG_CTRL, SIZE_HALF, {16'h0, CTRL_RESET});
    bus_read(REG_MODE, SIZE_HALF);
    bus_write(REG_BAUD, SIZE_HALF, 32'h0);
    bus_read(REG_BAUD, SIZE_HALF);
    drain_results();
  endtask

  task automatic test_pad_protocol();
    control_set(CTRL_SELECT);
    pad_byte(CARD_ADDR, 16'($urandom()));
    // A deselected machine ignores even its own address.
    pad_byte(PAD_ADDR, 16'($urandom()));
    bus_read(REG_STATUS, SIZE_HALF);
    control_set(16'h0);
    control_set(CTRL_SELECT);
    pad_byte(8'h55, 16'($urandom()));
    pad_byte(PAD_ADDR, 16'($urandom()));
    pad_byte(8'h00, 16'($urandom()));
    pad_byte(PAD_ADDR, 16'($urandom()));
    pad_byte(CMD_READ, 16'h0000);
    pad_byte(8'hFF, 16'($urandom()));
    bus_read(REG_DATA, SIZE_BYTE);
    pad_byte(8'h00, 16'($urandom()));
    pad_byte(8'h00, 16'($urandom()));
    bus_read(REG_STATUS, SIZE_WORD);
    pad_byte(PAD_ADDR, 16'($urandom()));
    pad_byte(CMD_READ, 16'hFFFF);
    pad_byte(8'h00, 16'($urandom()));
    pad_byte(8'h00, 16'($urandom()));
    pad_byte(8'h00, 16'($urandom()));
    control_set(CTRL_SELECT | CTRL_PORT2);
    pad_byte(PAD_ADDR, 16'($urandom()));
    bus_read(REG_STATUS, SIZE_HALF);
    drain_results();
  endtask

  task automatic test_ack_timer();
    control_set(CTRL_SELECT | CTRL_IRQEN);
    pad_byte(PAD_ADDR, 16'($urandom()));
    tick_run(50);
    // The second acknowledge restarts the countdown from the top.
    pad_byte(CMD_READ, 16'($urandom()));
    tick_run(int'(ACK_DELAY) - 1);
    bus_read(REG_STATUS, SIZE_WORD);
    tick_run(4);
    bus_read(REG_STATUS, SIZE_HALF);
    control_set(CTRL_SELECT | CTRL_IRQEN | CTRL_ACKIRQ);
    bus_read(REG_STATUS, SIZE_WORD);
    control_set(CTRL_SELECT);
    pad_byte(PAD_ADDR, 16'($urandom()));
    tick_run(int'(ACK_DELAY) + 2);
    pad_byte(CMD_READ, 16'($urandom()));
    control_set(16'h0);
    control_set(CTRL_SELECT | CTRL_IRQEN);
    tick_run(int'(ACK_DELAY) + 2);
    bus_read(REG_STATUS, SIZE_WORD);
    drain_results();
  endtask

  task automatic random_pad_transfer();
    logic [7:0]  seq [5];
    logic [15:0] v;
    if ($urandom_range(9) < 7) begin
      v = 16'($urandom());
      v = (v & ~(CTRL_RESET | CTRL_PORT2)) | CTRL_SELECT;
      if ($urandom_range(9) == 0) v = v | CTRL_PORT2;
      control_set(v);
    end
    seq[0] = PAD_ADDR;
    seq[1] = CMD_READ;
    for (int i = 2; i < 5; i++) seq[i] = 8'($urandom());
    for (int i = 0; i < 5; i++) begin
      if ($urandom_range(9) == 0) seq[i] = $urandom_range(1) ? CARD_ADDR : 8'($urandom());
      pad_byte(seq[i], 16'($urandom()));
      if ($urandom_range(9) < 3) bus_read(REG_DATA, 2'($urandom_range(SIZE_WIDE, SIZE_BYTE)));
      if ($urandom_range(9) == 0) bus_read(REG_STATUS, 2'($urandom_range(SIZE_WIDE, SIZE_BYTE)));
      if ($urandom_range(9) == 0) tick_run($urandom_range(1, 4));
    end
  endtask

  task automatic random_scenario();
    int unsigned pick;
    bus_op_t op;
    logic [15:0] v;
    pick = $urandom_range(99);
    if (pick < 45) begin
      random_pad_transfer();
    end else if (pick < 60) begin
      if ($urandom_range(9) < 3)
        tick_run($urandom_range(int'(ACK_DELAY) + 3, int'(ACK_DELAY) - 3));
      else
        tick_run($urandom_range(1, 8));
    end else if (pick < 85) begin
      op = make_op(2'($urandom()), 3'($urandom()), 2'($urandom()), $urandom(),
                   16'($urandom()));
      // Keep full resets rare so the pad machine gets somewhere.
      if (op.action == ACT_WRITE && op.sel == REG_CTRL && $urandom_range(9) != 0)
        op.wdata[CT_RESET] = 1'b0;
      send_op(op);
    end else begin
      v = 16'($urandom());
      v = v & ~(CTRL_SELECT | CTRL_RESET | CTRL_PORT2);
      control_set(v);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned gaps [4];
    int unsigned stalls [4];
    int unsigned stop_at;
    gaps = '{0, 78, 0, 6};
    stalls = '{0, 0, 78, 6};
    for (int p = 0; p < 4; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      stop_at = items_sent + 25;
      while (items_sent < stop_at) random_scenario();
      drain_results();
    end
  endtask

  initial begin
    port_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_file();
    test_pad_protocol();
    gap_pct = 6;
    stall_pct = 6;
    test_ack_timer();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (fault_count == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[pad_serial_port_controller_top.f]
hw/rtl/pscp_pkg.sv
hw/rtl/pscp_front.sv
hw/rtl/pscp_queue.sv
hw/rtl/pscp_back.sv
hw/rtl/pad_serial_port_controller_top.sv
tb/pad_serial_port_controller_top_test.sv
